@@ src/txc_pkg.sv @@
package txc_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int COLOR_W = 4;
  localparam int CELL_W  = 16;
  localparam int REG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_PUT     = 2'd0;
  localparam logic [OP_W-1:0] OP_NEWLINE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_FG = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_BG = 1'd1;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

  localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
  localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
  } res_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [COLOR_W-1:0] fg,
                                                  input logic [COLOR_W-1:0] bg);
    make_cell = {bg, fg, ch};
  endfunction

  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BG, RESET_FG, CHAR_SPACE};

endpackage

@@ src/text_console_writer.sv @@
// Text console writer over a COLUMNS x ROWS screen store of 16-bit cells
// (character in the low byte, attribute in the high byte).
// Command channel: a command transfers at a clock edge with start high and
// busy low. Result channel: done is high for one cycle with result valid;
// the receiver must take it then, it cannot stall the block.
// Config port: cfg_write with cfg_index 0 (foreground) or 1 (background)
// writes cfg_data at once; write only while the block is idle.
// Path from the transfer edge to done, per command:
//   put, newline, read out of range: done comes straight from the idle state, next command may follow at once
//   read in range: done from S_READ, after a synchronous read of the screen store
//   newline on the bottom row, or put past the end of the bottom row: rows move up in
//     S_SCROLL, S_BLANK blanks the bottom row, then S_PUT writes a put's character
//   clear: S_BLANK blanks every cell, and the cursor homes
// The screen store has a single write port: during scroll and clear
// one cell moves or blanks per cycle.
// Reset: cursor homes, colors go to white on black, and a sweep writes blank
// cells over the whole screen store while busy stays high; config writes are
// taken during the sweep.
module text_console_writer
  import txc_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 command,
  output logic                 done,
  output res_t                 result,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] COPY_A   = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_END  = CW'(COLUMNS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_BLANK  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;

  logic [2:0]         state, state_next;
  logic [AW-1:0]      ptr, ptr_next;
  logic [CW-1:0]      col, col_next;
  logic [RW-1:0]      row, row_next;
  logic               put_pend, put_pend_next;
  logic [CHAR_W-1:0]  char_q, char_next;
  logic [COLOR_W-1:0] fg, bg;
  logic               done_next;
  res_t               res_next;

  logic [CELL_W-1:0]  mem [CELLS];
  logic [CELL_W-1:0]  rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  logic               wrap;
  logic [RW-1:0]      wr_row;
  logic [CW-1:0]      wr_col;
  logic [AW-1:0]      cur_addr;
  logic [AW-1:0]      read_addr;
  logic               read_ok;
  logic [CELL_W-1:0]  blank;
  logic [CHAR_W-1:0]  cc, ca;

  assign busy      = (state != S_IDLE);
  assign wrap      = (col == COL_END);
  assign wr_row    = wrap ? RW'(row + 1'b1) : row;
  assign wr_col    = wrap ? '0 : col;
  assign cur_addr  = AW'(wr_row) * COLS_A + AW'(wr_col);
  assign read_addr = AW'(command.read_row) * COLS_A + AW'(command.read_col);
  assign read_ok   = (int'(command.read_row) < ROWS) && (int'(command.read_col) < COLUMNS);
  assign blank     = make_cell(CHAR_SPACE, fg, bg);

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    col_next      = col;
    row_next      = row;
    put_pend_next = put_pend;
    char_next     = char_q;
    done_next     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = ptr;
    mem_wdata     = blank;
    rd_en         = 1'b0;
    rd_addr       = read_addr;
    cc            = '0;
    ca            = '0;

    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
        if (ptr == LAST_A) begin
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (command.operation == OP_CLEAR) begin
            col_next      = '0;
            row_next      = '0;
            ptr_next      = '0;
            put_pend_next = 1'b0;
            state_next    = S_BLANK;
          end else if (command.operation == OP_READ) begin
            if (read_ok) begin
              rd_en      = 1'b1;
              state_next = S_READ;
            end else begin
              done_next = 1'b1;
            end
          end else if (command.operation == OP_NEWLINE ||
                       command.char_code == CHAR_NEWLINE) begin
            col_next = '0;
            if (row != ROW_LAST) begin
              row_next  = RW'(row + 1'b1);
              done_next = 1'b1;
            end else begin
              ptr_next      = '0;
              put_pend_next = 1'b0;
              state_next    = S_SCROLL;
            end
          end else if (wrap && row == ROW_LAST) begin
            col_next      = '0;
            ptr_next      = '0;
            put_pend_next = 1'b1;
            char_next     = command.char_code;
            state_next    = S_SCROLL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = make_cell(command.char_code, fg, bg);
            col_next  = CW'(wr_col + 1'b1);
            row_next  = wr_row;
            done_next = 1'b1;
          end
        end
      end
      S_SCROLL: begin
        // read one row ahead, write back the cell read last cycle
        if (ptr != COPY_A) begin
          rd_en   = 1'b1;
          rd_addr = ptr + COLS_A;
        end
        if (ptr != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ptr - 1'b1;
          mem_wdata = rdata;
        end
        if (ptr == COPY_A) begin
          state_next = S_BLANK;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_BLANK: begin
        mem_we = 1'b1;
        if (ptr == LAST_A) begin
          if (put_pend) begin
            state_next = S_PUT;
          end else begin
            state_next = S_IDLE;
            done_next  = 1'b1;
          end
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_PUT: begin
        mem_we        = 1'b1;
        mem_waddr     = COPY_A;
        mem_wdata     = make_cell(char_q, fg, bg);
        col_next      = CW'(1);
        put_pend_next = 1'b0;
        done_next     = 1'b1;
        state_next    = S_IDLE;
      end
      S_READ: begin
        cc         = rdata[CHAR_W-1:0];
        ca         = rdata[CELL_W-1:CHAR_W];
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next            = result;
    res_next.cursor_col = COL_W'(col_next);
    res_next.cursor_row = ROW_W'(row_next);
    res_next.cell_char  = cc;
    res_next.cell_attr  = ca;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      ptr      <= '0;
      col      <= '0;
      row      <= '0;
      put_pend <= 1'b0;
      done     <= 1'b0;
      fg       <= RESET_FG;
      bg       <= RESET_BG;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      col      <= col_next;
      row      <= row_next;
      put_pend <= put_pend_next;
      done     <= done_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_FG:  fg <= cfg_data;
          REG_BG:  bg <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    char_q <= char_next;
    if (done_next) begin
      result <= res_next;
    end
  end

`ifndef SYNTH
  a_no_done_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !done)
    else $error("result during reset sweep");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(col) <= COLUMNS) && (int'(row) < ROWS))
    else $error("cursor out of range");

  a_read_follow: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.operation == OP_READ) |=> (state == S_READ) || done)
    else $error("read command lost");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (int'(mem_waddr) < CELLS))
    else $error("screen write out of range");
`endif

endmodule
